### rtl/core/snh_pkg.sv
// Shared types and constants for the symbol n-gram histogram.
// Used by every module under rtl/core except snh_ram; depends on nothing.
package snh_pkg;

    localparam int SYMBOL_BITS     = 5;   // width of one symbol digit
    localparam int IDX_BITS        = 15;  // width of the entry_index field
    localparam int CFG_BITS        = 2;   // width of the window_length register
    localparam int OUT_COUNT_BITS  = 32;  // width of the count result field
    localparam int QUEUE_DEPTH     = 4;   // entries between front and back
    localparam int DEF_MAX_WINDOW  = 3;
    localparam int DEF_COUNT_BITS  = 32;

    // Queue operation codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Fill status of the queue between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### rtl/core/snh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the count table.
module snh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/snh_fifo.sv
// Small register queue carrying classified operations from front to back.
// Depends on snh_pkg for its depth and status type.
module snh_fifo #(
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output snh_pkg::t_q_status o_status
);

    localparam int DEPTH = snh_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    logic [DATA_W-1:0] r_entry [DEPTH];
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [PW:0]       r_fill,   n_fill;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + (PW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    assign o_data          = r_entry[r_rd_ptr];
    assign o_status.full   = (r_fill == (PW+1)'(DEPTH));
    assign o_status.empty  = (r_fill == '0);

endmodule

### rtl/core/snh_front.sv
// Front end: accepts transactions, keeps the symbol history ring and the
// window length, and turns each transaction into a table address. Uses snh_pkg.
module snh_front #(
    parameter int MAX_WINDOW = snh_pkg::DEF_MAX_WINDOW
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [snh_pkg::CFG_BITS-1:0]          i_cfg_window_length,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_func,
    input  logic [snh_pkg::SYMBOL_BITS-1:0]       i_symbol,
    input  logic [snh_pkg::IDX_BITS-1:0]          i_entry_index,
    input  snh_pkg::t_q_status                    i_q_status,
    input  logic                                  i_clearing,
    output logic                                  o_push,
    output logic                                  o_push_op,
    output logic [snh_pkg::SYMBOL_BITS*MAX_WINDOW-1:0] o_push_addr
);

    localparam int SB = snh_pkg::SYMBOL_BITS;
    localparam int AW = SB * MAX_WINDOW;
    localparam int NW = $clog2(MAX_WINDOW + 1) + 1;
    localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int XW = AW + snh_pkg::IDX_BITS;

    logic [snh_pkg::CFG_BITS-1:0] r_window_length, n_window_length;
    logic [SW-1:0]                r_write_slot,    n_write_slot;
    logic [SB-1:0]                r_history [MAX_WINDOW];

    logic [NW-1:0] act_len;
    logic [NW-1:0] cur_slot;
    logic [NW-1:0] next_slot;
    logic [AW-1:0] push_addr;
    logic [AW-1:0] read_addr;
    logic [XW-1:0] idx_ext;
    logic          accept;

    assign o_ready = !i_q_status.full && !i_clearing;
    assign accept  = i_valid && o_ready;

    // Active window length: zero acts as one, large values clamp.
    always_comb begin
        logic [NW-1:0] wl;
        wl = NW'(r_window_length);
        if (wl == '0) begin
            act_len = NW'(1);
        end else if (wl > NW'(MAX_WINDOW)) begin
            act_len = NW'(MAX_WINDOW);
        end else begin
            act_len = wl;
        end
    end

    always_comb begin
        logic [NW-1:0] bump;
        cur_slot  = (NW'(r_write_slot) >= act_len) ? '0 : NW'(r_write_slot);
        bump      = cur_slot + NW'(1);
        next_slot = (bump == act_len) ? '0 : bump;
    end

    // Digit d holds the symbol of age act_len-1-d, so the newest symbol lands
    // in the top digit. The symbol being pushed replaces its slot here.
    always_comb begin
        logic [NW-1:0] pos;
        push_addr = '0;
        for (int d = 0; d < MAX_WINDOW; d++) begin
            pos = next_slot + NW'(d);
            if (pos >= act_len) begin
                pos = pos - act_len;
            end
            if (NW'(d) < act_len) begin
                push_addr[d*SB +: SB] = (pos == cur_slot) ? i_symbol : r_history[pos[SW-1:0]];
            end
        end
    end

    // Read index keeps only the digits of the active window.
    always_comb begin
        idx_ext   = XW'(i_entry_index);
        read_addr = '0;
        for (int d = 0; d < MAX_WINDOW; d++) begin
            if (NW'(d) < act_len) begin
                read_addr[d*SB +: SB] = idx_ext[d*SB +: SB];
            end
        end
    end

    always_comb begin
        n_window_length = r_window_length;
        n_write_slot    = r_write_slot;
        if (i_cfg_valid) begin
            n_window_length = i_cfg_window_length;
            n_write_slot    = '0;
        end else if (accept && (i_func == snh_pkg::OP_PUSH)) begin
            n_write_slot = next_slot[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= snh_pkg::CFG_BITS'(1);
            r_write_slot    <= '0;
            for (int s = 0; s < MAX_WINDOW; s++) begin
                r_history[s] <= '0;
            end
        end else begin
            r_window_length <= n_window_length;
            r_write_slot    <= n_write_slot;
            if (accept && (i_func == snh_pkg::OP_PUSH)) begin
                r_history[cur_slot[SW-1:0]] <= i_symbol;
            end
        end
    end

    assign o_push      = accept;
    assign o_push_op   = i_func;
    assign o_push_addr = (i_func == snh_pkg::OP_READ) ? read_addr : push_addr;

endmodule

### rtl/core/snh_back.sv
// Back end: clears the count table after reset, then runs queued reads and
// saturating increments against it with forwarding. Uses snh_pkg and snh_ram.
module snh_back #(
    parameter int MAX_WINDOW = snh_pkg::DEF_MAX_WINDOW,
    parameter int COUNT_BITS = snh_pkg::DEF_COUNT_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  snh_pkg::t_q_status                    i_q_status,
    input  logic                                  i_q_op,
    input  logic [snh_pkg::SYMBOL_BITS*MAX_WINDOW-1:0] i_q_addr,
    output logic                                  o_q_pop,
    output logic                                  o_clearing,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [snh_pkg::OUT_COUNT_BITS-1:0]    o_count,
    output logic                                  o_nonzero
);

    localparam int AW = snh_pkg::SYMBOL_BITS * MAX_WINDOW;
    localparam int OW = snh_pkg::OUT_COUNT_BITS;

    logic                  r_clearing;
    logic [AW-1:0]         r_clr_addr;
    logic                  r_s1_valid;
    logic                  r_s1_op;
    logic [AW-1:0]         r_s1_addr;
    logic                  r_fwd_valid;
    logic [AW-1:0]         r_fwd_addr;
    logic [COUNT_BITS-1:0] r_fwd_data;
    logic                  r_out_valid;
    logic [OW-1:0]         r_out_count;
    logic                  r_out_nonzero;

    logic                  out_free;
    logic                  s1_stall;
    logic                  issue;
    logic                  s1_push;
    logic                  s1_read;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] bumped;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;

    assign out_free = !r_out_valid || i_ready;
    assign s1_push  = r_s1_valid && (r_s1_op == snh_pkg::OP_PUSH);
    assign s1_read  = r_s1_valid && (r_s1_op == snh_pkg::OP_READ);
    assign s1_stall = s1_read && !out_free;
    assign issue    = !r_clearing && !i_q_status.empty && !s1_stall;

    // The previous increment was written at the same edge that captured this
    // read, so its value must be taken from the forward register.
    assign cur    = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : ram_rdata;
    assign bumped = (&cur) ? cur : cur + COUNT_BITS'(1);

    always_comb begin
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_push;
            ram_waddr = r_s1_addr;
            ram_wdata = bumped;
        end
    end

    snh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (1 << AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (i_q_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (&r_clr_addr) begin
                    r_clearing <= 1'b0;
                end
            end
            if (!s1_stall) begin
                r_s1_valid  <= issue;
                r_fwd_valid <= s1_push;
            end
            if (s1_read && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s1_stall) begin
            r_s1_op    <= i_q_op;
            r_s1_addr  <= i_q_addr;
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= bumped;
        end
        if (s1_read && out_free) begin
            r_out_count   <= OW'({{OW{1'b0}}, cur});
            r_out_nonzero <= (cur != '0);
        end
    end

    assign o_q_pop    = issue;
    assign o_clearing = r_clearing;
    assign o_valid    = r_out_valid;
    assign o_count    = r_out_count;
    assign o_nonzero  = r_out_nonzero;

endmodule

### rtl/core/symbol_ngram_histogram_top.sv
// Top level of the symbol n-gram histogram: front end, queue and back end.
// Depends on snh_pkg, snh_front, snh_fifo, snh_back and snh_ram.
//
// Usage:
// The input channel (i_valid / o_ready) carries one transaction per item.
// With i_func at push, i_symbol enters the history ring and the window it
// completes is counted in the table; no result is returned. With i_func at
// read, the count at i_entry_index (masked to the active window's digits)
// comes back on the result channel (o_valid / i_ready) as o_count, o_nonzero.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes window_length
// and restarts the ring slot; it is always ready and should only be used
// while the block is idle.
// Throughput is one transaction per cycle while results are taken; a read
// result passes the queue, the table read stage and the output register.
// The back end writes each increment from the stage that holds its table
// read; a forward register covers back-to-back increments of one window.
// After reset the back end clears the table, one entry per cycle, over all
// 2^(5*MAX_WINDOW) entries (32768 by default); o_ready stays low meanwhile.
// When the receiver stalls, one result is held in the output register and
// further transactions collect in a four-entry queue before o_ready drops.
module symbol_ngram_histogram_top #(
    parameter int MAX_WINDOW = snh_pkg::DEF_MAX_WINDOW,
    parameter int COUNT_BITS = snh_pkg::DEF_COUNT_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [snh_pkg::CFG_BITS-1:0]       i_cfg_window_length,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_func,
    input  logic [snh_pkg::SYMBOL_BITS-1:0]    i_symbol,
    input  logic [snh_pkg::IDX_BITS-1:0]       i_entry_index,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [snh_pkg::OUT_COUNT_BITS-1:0] o_count,
    output logic                               o_nonzero
);

    localparam int AW = snh_pkg::SYMBOL_BITS * MAX_WINDOW;

    snh_pkg::t_q_status q_status;
    logic               q_push;
    logic               q_push_op;
    logic [AW-1:0]      q_push_addr;
    logic               q_pop;
    logic               q_op;
    logic [AW-1:0]      q_addr;
    logic               clearing;

    // The register write never waits.
    assign o_cfg_ready = 1'b1;

    snh_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_window_length (i_cfg_window_length),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_func              (i_func),
        .i_symbol            (i_symbol),
        .i_entry_index       (i_entry_index),
        .i_q_status          (q_status),
        .i_clearing          (clearing),
        .o_push              (q_push),
        .o_push_op           (q_push_op),
        .o_push_addr         (q_push_addr)
    );

    // Each queue entry is the operation code above the table address.
    snh_fifo #(
        .DATA_W (AW + 1)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   ({q_push_op, q_push_addr}),
        .i_pop    (q_pop),
        .o_data   ({q_op, q_addr}),
        .o_status (q_status)
    );

    snh_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_op     (q_op),
        .i_q_addr   (q_addr),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_count    (o_count),
        .o_nonzero  (o_nonzero)
    );

`ifndef SYNTHESIS
    // The back end never takes from an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue popped while empty");

    // The front end never writes into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("queue pushed while full");

    // While the table is being cleared, nothing moves through the queue.
    a_quiet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (!q_push && !q_pop))
        else $error("queue activity during table clear");

    // A result can only appear after the clearing pass has finished.
    a_no_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_valid)
        else $error("result issued during table clear");
`endif

endmodule
